[hdl/grm_pkg.sv]
// ============================================================================
// grm_pkg
// Shared types and constants of the 3x3 gray morphology block: word layouts,
// register indexes, operation codes and the command passed from the front
// part to the back part.
// ============================================================================
package grm_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // field widths
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DILATE_MODE  = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0] RESET_DIM = 11'd1024;

    // operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // brightest gray value, identity of the minimum
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // entries of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // input word
    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } out_word_t;

    // one advance of the sample stream, with the edge flags of the
    // window center when it yields a result
    typedef struct packed {
        logic             emit;
        logic             frame_end;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bottom_ok;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

endpackage

[hdl/grm_front.sv]
// ============================================================================
// grm_front
// Accepts input words, tracks the frame position and decides for each word
// whether it advances the sample stream and whether a result comes out.
// Issues one command per advance into the queue.
// ============================================================================
module grm_front
    import grm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [DIM_W-1:0]              frame_width,
    input  logic [DIM_W-1:0]              frame_height,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  in_word_t                      in_word,
    input  logic                          q_full,
    output logic                          q_push,
    output cmd_t                          q_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]  q_addr
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // frame size minus one, latched at the first pixel
    logic [XW-1:0] wm1_reg;
    logic [YW-1:0] hm1_reg;
    // position of the next sample
    logic [XW-1:0] sx_reg;
    logic [YW-1:0] sy_reg;
    // position of the next result
    logic [XW-1:0] rx_reg;
    logic [YW-1:0] ry_reg;
    logic          all_in_reg;
    logic          dummy_reg;

    logic          accept;
    logic          first;
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;
    logic          push_adv;
    logic          flush_adv;
    logic          dummy_adv;
    logic          adv;
    logic          emit;
    logic          fend;
    logic          row_end;
    logic          last_pix;

    function automatic logic [XW-1:0] clamp_w(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] vm1;
        vm1 = v - DIM_W'(1);
        if (v == '0)
            return '0;
        else if (32'(v) > MAX_WIDTH)
            return XW'(MAX_WIDTH - 1);
        else
            return XW'(vm1);
    endfunction

    function automatic logic [YW-1:0] clamp_h(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] vm1;
        vm1 = v - DIM_W'(1);
        if (v == '0)
            return '0;
        else if (32'(v) > MAX_HEIGHT)
            return YW'(MAX_HEIGHT - 1);
        else
            return YW'(vm1);
    endfunction

    // handshake: hold off while the queue is full or a pad sample is due
    assign in_stall = q_full || dummy_reg;
    assign accept   = in_valid && !in_stall;

    // frame size in effect
    assign first = (sx_reg == '0) && (sy_reg == '0) && !all_in_reg;
    assign wm1   = first ? clamp_w(frame_width)  : wm1_reg;
    assign hm1   = first ? clamp_h(frame_height) : hm1_reg;

    // word classification
    assign push_adv  = accept && (in_word.operation == OP_PUSH) && !all_in_reg;
    assign flush_adv = accept && (in_word.operation == OP_FLUSH) && all_in_reg;
    assign dummy_adv = dummy_reg && !q_full;
    assign adv       = push_adv || flush_adv || dummy_adv;

    // a pushed pixel completes a neighborhood once a row and one more are in
    assign emit = flush_adv ||
                  (push_adv && ((32'(sy_reg) >= 32'd2) ||
                                ((sy_reg == YW'(1)) && (sx_reg != '0))));
    assign fend     = emit && (rx_reg == wm1_reg) && (ry_reg == hm1_reg);
    assign row_end  = (sx_reg == wm1);
    assign last_pix = push_adv && row_end && (sy_reg == hm1);

    // command to the back part
    assign q_push          = adv;
    assign q_addr          = sx_reg;
    assign q_cmd.emit      = emit;
    assign q_cmd.frame_end = fend;
    assign q_cmd.left_ok   = (rx_reg != '0);
    assign q_cmd.right_ok  = (rx_reg != wm1_reg);
    assign q_cmd.top_ok    = (ry_reg != '0);
    assign q_cmd.bottom_ok = (ry_reg != hm1_reg);
    assign q_cmd.pixel     = in_word.pixel_in;

    // frame size latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg <= clamp_w(RESET_DIM);
            hm1_reg <= clamp_h(RESET_DIM);
        end
        else if (push_adv && first)
        begin
            wm1_reg <= wm1;
            hm1_reg <= hm1;
        end
    end

    // sample and result positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg     <= '0;
            sy_reg     <= '0;
            rx_reg     <= '0;
            ry_reg     <= '0;
            all_in_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (fend)
            begin
                sx_reg     <= '0;
                sy_reg     <= '0;
                rx_reg     <= '0;
                ry_reg     <= '0;
                all_in_reg <= 1'b0;
            end
            else
            begin
                sx_reg <= row_end ? '0 : sx_reg + XW'(1);
                if (push_adv && row_end)
                begin
                    if (sy_reg == hm1)
                        all_in_reg <= 1'b1;
                    else
                        sy_reg <= sy_reg + YW'(1);
                end
                if (emit)
                begin
                    if (rx_reg == wm1_reg)
                    begin
                        rx_reg <= '0;
                        ry_reg <= ry_reg + YW'(1);
                    end
                    else
                    begin
                        rx_reg <= rx_reg + XW'(1);
                    end
                end
            end
        end
    end

    // one-row frame: one pad sample after the last pixel aligns the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dummy_reg <= 1'b0;
        else if (last_pix && (hm1 == '0))
            dummy_reg <= 1'b1;
        else if (dummy_adv)
            dummy_reg <= 1'b0;
    end

endmodule

[hdl/grm_fifo.sv]
// ============================================================================
// grm_fifo
// Short first-in first-out queue between the front and the back part.
// ============================================================================
module grm_fifo
    import grm_pkg::*;
#(
    parameter int DATA_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] store_mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;

    assign full     = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                2'b11:   count_reg <= count_reg;
                2'b00:   count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hdl/grm_back.sv]
// ============================================================================
// grm_back
// Carries out the commands: two line stores in one memory, the 3x3 window
// registers, edge masking and the minimum or maximum over the neighbors,
// into the output register.
// ============================================================================
module grm_back
    import grm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         dilate_mode,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  cmd_t                         q_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
    output logic                         out_valid,
    input  logic                         out_stall,
    output out_word_t                    out_word
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = 2 * PIX_W;

    // line stores: low byte one row back, high byte two rows back
    logic [LW-1:0]    line_mem [MAX_WIDTH];
    logic [LW-1:0]    rd_reg;
    logic             byp_reg;
    logic [LW-1:0]    byp_data_reg;

    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic [XW-1:0]    s1_addr_reg;
    logic             s2_valid_reg;
    cmd_t             s2_cmd_reg;

    // window: index 0 is the newest column
    logic [PIX_W-1:0] top_reg [3];
    logic [PIX_W-1:0] mid_reg [3];
    logic [PIX_W-1:0] bot_reg [3];

    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic             en;
    logic [LW-1:0]    rd_eff;
    logic [LW-1:0]    wr_data;
    logic [PIX_W-1:0] ident;
    logic [PIX_W-1:0] nb [8];
    logic [7:0]       nb_ok;
    logic [PIX_W-1:0] cand [8];
    logic [PIX_W-1:0] lvl1 [4];
    logic [PIX_W-1:0] lvl2 [2];
    logic [PIX_W-1:0] result;

    function automatic logic [PIX_W-1:0] pick(input logic dil,
                                              input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        if (dil)
            return (a > b) ? a : b;
        else
            return (a < b) ? a : b;
    endfunction

    // whole back part moves when the output register can take a word
    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && !q_empty;

    // forward the word written in the same cycle as the read
    assign rd_eff  = byp_reg ? byp_data_reg : rd_reg;
    assign wr_data = {rd_eff[PIX_W-1:0], s1_cmd_reg.pixel};

    // line store memory
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_pop)
                rd_reg <= line_mem[q_addr];
            if (s1_valid_reg)
                line_mem[s1_addr_reg] <= wr_data;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_pop)
            begin
                s1_cmd_reg   <= q_cmd;
                s1_addr_reg  <= q_addr;
                byp_reg      <= s1_valid_reg && (s1_addr_reg == q_addr);
                byp_data_reg <= wr_data;
            end
            if (s1_valid_reg)
                s2_cmd_reg <= s1_cmd_reg;
            if (s2_valid_reg && s2_cmd_reg.emit)
            begin
                out_word_reg.pixel_out <= result;
                out_word_reg.frame_end <= s2_cmd_reg.frame_end;
            end
        end
    end

    // window shift
    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            bot_reg[2] <= bot_reg[1];
            bot_reg[1] <= bot_reg[0];
            bot_reg[0] <= s1_cmd_reg.pixel;
            mid_reg[2] <= mid_reg[1];
            mid_reg[1] <= mid_reg[0];
            mid_reg[0] <= rd_eff[PIX_W-1:0];
            top_reg[2] <= top_reg[1];
            top_reg[1] <= top_reg[0];
            top_reg[0] <= rd_eff[LW-1:PIX_W];
        end
    end

    // stage valids and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_cmd_reg.emit;
        end
    end

    // neighbors of the center mid_reg[1] and their in-frame flags
    always_comb
    begin
        nb[0]    = top_reg[2];
        nb[1]    = top_reg[1];
        nb[2]    = top_reg[0];
        nb[3]    = mid_reg[2];
        nb[4]    = mid_reg[0];
        nb[5]    = bot_reg[2];
        nb[6]    = bot_reg[1];
        nb[7]    = bot_reg[0];
        nb_ok[0] = s2_cmd_reg.top_ok && s2_cmd_reg.left_ok;
        nb_ok[1] = s2_cmd_reg.top_ok;
        nb_ok[2] = s2_cmd_reg.top_ok && s2_cmd_reg.right_ok;
        nb_ok[3] = s2_cmd_reg.left_ok;
        nb_ok[4] = s2_cmd_reg.right_ok;
        nb_ok[5] = s2_cmd_reg.bottom_ok && s2_cmd_reg.left_ok;
        nb_ok[6] = s2_cmd_reg.bottom_ok;
        nb_ok[7] = s2_cmd_reg.bottom_ok && s2_cmd_reg.right_ok;
    end

    // masked minimum or maximum, three levels of compare
    always_comb
    begin
        ident = dilate_mode ? '0 : PIX_MAX;
        for (int i = 0; i < 8; i++)
            cand[i] = nb_ok[i] ? nb[i] : ident;
        for (int i = 0; i < 4; i++)
            lvl1[i] = pick(dilate_mode, cand[2*i], cand[2*i+1]);
        for (int i = 0; i < 2; i++)
            lvl2[i] = pick(dilate_mode, lvl1[2*i], lvl1[2*i+1]);
        result = pick(dilate_mode, lvl2[0], lvl2[1]);
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[hdl/grey_morphology_3x3.sv]
// ============================================================================
// grey_morphology_3x3
// Streaming 3x3 gray erosion or dilation over the eight neighbors of each
// pixel, with out-of-frame neighbors skipped.
// ============================================================================
// Takes one word per clock unless in_stall is high, pixels and flush steps
// alike, and gives at most one result word per clock unless out_stall holds
// it. The pace is set by the line store memory, which does one read and one
// write per clock. A single-row frame needs one pad sample after its last
// pixel, during which the input is stalled. The word that completes a
// neighborhood passes the queue, the line store read and the window and
// output registers. While a result waits on the output the back part holds,
// and the four-entry queue takes up to four more words before the input
// stalls. The frame size is taken when the first pixel of a frame arrives;
// the erode/dilate choice applies to each result as it is computed. After
// the last pixel, each flush word drains one pending result (frame_width + 1
// of them for frames of two or more rows); the last carries frame_end. The line store needs no clearing after reset.
// ============================================================================
module grey_morphology_3x3
    import grm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_word
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int DATA_W = XW + $bits(cmd_t);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             dilate_reg;

    logic             q_push;
    cmd_t             q_cmd_in;
    logic [XW-1:0]    q_addr_in;
    logic             q_full;
    logic             q_pop;
    logic [DATA_W-1:0] q_head;
    logic             q_empty;
    cmd_t             q_cmd_out;
    logic [XW-1:0]    q_addr_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_DIM;
            height_reg <= RESET_DIM;
            dilate_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_DILATE_MODE:  dilate_reg <= cfg_data[0];
                default:          dilate_reg <= dilate_reg;
            endcase
        end
    end

    // front: classification and frame position
    grm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd_in),
        .q_addr       (q_addr_in)
    );

    // command queue
    grm_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({q_addr_in, q_cmd_in}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    assign q_addr_out = q_head[DATA_W-1:$bits(cmd_t)];
    assign q_cmd_out  = q_head[$bits(cmd_t)-1:0];

    // back: line stores, window and neighbor reduction
    grm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .dilate_mode (dilate_reg),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd_out),
        .q_addr      (q_addr_out),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word)
    );

endmodule
